>>> hw/rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared types, constants and the arctangent table for the spherical to
// Cartesian point converter.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int CORDIC_STEPS       = 24;
  localparam int TRIG_FRACTION_BITS = 30;
  localparam int TRIG_DROP          = 30 - TRIG_FRACTION_BITS;
  localparam int MAG_SHIFT          = 2 * TRIG_FRACTION_BITS - 32;

  localparam int ANGLE_W  = 16;
  localparam int RESID_W  = 14;
  localparam int CORDIC_W = 34;
  localparam int TRIG_W   = 32;
  localparam int DEPTH_W  = 32;
  localparam int COORD_W  = 32;

  // input register, fold stages before the CORDIC, CORDIC steps, fold, products
  localparam int PIPE_DEPTH = CORDIC_STEPS + 6;
  localparam int DEPTH_TAP  = CORDIC_STEPS + 2;

  localparam logic [ANGLE_W-1:0] CENTIDEG_FULL    = 16'd36000;
  localparam logic [ANGLE_W-1:0] CENTIDEG_HALF    = 16'd18000;
  localparam logic [ANGLE_W-1:0] CENTIDEG_3QUART  = 16'd27000;
  localparam logic [ANGLE_W-1:0] CENTIDEG_QUARTER = 16'd9000;

  localparam logic [33:0] RAD_PER_CENTIDEG_Q46 = 34'd12281662764;
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'd652032874;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [ANGLE_W-1:0] polar_centideg;
    logic [ANGLE_W-1:0] azimuth_centideg;
    logic [7:0]         reflect_in;
    logic [7:0]         tag_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] z_mm;
    logic [7:0]                reflect_out;
    logic [7:0]                tag_out;
    logic                      last_out;
  } out_word_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [7:0]         reflect;
    logic [7:0]         tag;
    logic               last;
  } side_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;  1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;  3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;  5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;  7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;  9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;  15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;  19: v = 32'h000007FF;
      20: v = 32'h000003FF;  21: v = 32'h000001FF;
      22: v = 32'h000000FF;  23: v = 32'h0000007F;
      24: v = 32'h0000003F;  25: v = 32'h0000001F;
      26: v = 32'h0000000F;  27: v = 32'h00000008;
      28: v = 32'h00000004;  29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/s2c_angle_prep.sv
// ----------------------------------------------------------------------------
// s2c_angle_prep
// Two stages: wrap the angle into one turn and split off the quadrant, then
// scale the residual to radians in Q2.30.
// ----------------------------------------------------------------------------
module s2c_angle_prep
  import s2c_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic [ANGLE_W-1:0]         angle,
  output logic signed [CORDIC_W-1:0] z_out,
  output quad_t                      quad_out
);

  logic [ANGLE_W-1:0] wrapped;
  logic [ANGLE_W-1:0] resid_wide;
  quad_t              quad_next;
  logic [RESID_W-1:0] resid;
  quad_t              quad;
  logic [48:0]        rad_prod;

  always_comb begin
    wrapped = (angle >= CENTIDEG_FULL) ? angle - CENTIDEG_FULL : angle;
    if (wrapped >= CENTIDEG_3QUART) begin
      quad_next  = QUAD_3;
      resid_wide = wrapped - CENTIDEG_3QUART;
    end else if (wrapped >= CENTIDEG_HALF) begin
      quad_next  = QUAD_2;
      resid_wide = wrapped - CENTIDEG_HALF;
    end else if (wrapped >= CENTIDEG_QUARTER) begin
      quad_next  = QUAD_1;
      resid_wide = wrapped - CENTIDEG_QUARTER;
    end else begin
      quad_next  = QUAD_0;
      resid_wide = wrapped;
    end
  end

  // round half up on the way from Q46 to Q30
  assign rad_prod = 49'(resid) * 49'(RAD_PER_CENTIDEG_Q46) + 49'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      resid    <= resid_wide[RESID_W-1:0];
      quad     <= quad_next;
      z_out    <= signed'({2'b00, rad_prod[47:16]});
      quad_out <= quad;
    end
  end

endmodule

>>> hw/rtl/s2c_cordic.sv
// ----------------------------------------------------------------------------
// s2c_cordic
// Rotation-mode CORDIC, one iteration per register stage, followed by a
// stage that folds the quadrant back in and drops surplus fraction bits.
// ----------------------------------------------------------------------------
module s2c_cordic
  import s2c_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [CORDIC_W-1:0] z_in,
  input  quad_t                      quad_in,
  output logic signed [TRIG_W-1:0]   sin_out,
  output logic signed [TRIG_W-1:0]   cos_out
);

  logic signed [CORDIC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] zs [CORDIC_STEPS+1];
  quad_t                      qs [CORDIC_STEPS+1];

  logic signed [CORDIC_W-1:0] s_fold;
  logic signed [CORDIC_W-1:0] c_fold;
  logic signed [CORDIC_W-1:0] s_drop;
  logic signed [CORDIC_W-1:0] c_drop;

  assign xs[0] = CORDIC_GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign qs[0] = quad_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] atan_c;
    assign atan_c = signed'({2'b00, atan_q30(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_c;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_c;
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  always_comb begin
    case (qs[CORDIC_STEPS])
      QUAD_0: begin
        s_fold = ys[CORDIC_STEPS];
        c_fold = xs[CORDIC_STEPS];
      end
      QUAD_1: begin
        s_fold = xs[CORDIC_STEPS];
        c_fold = -ys[CORDIC_STEPS];
      end
      QUAD_2: begin
        s_fold = -ys[CORDIC_STEPS];
        c_fold = -xs[CORDIC_STEPS];
      end
      default: begin
        s_fold = -xs[CORDIC_STEPS];
        c_fold = ys[CORDIC_STEPS];
      end
    endcase
    s_drop = s_fold >>> TRIG_DROP;
    c_drop = c_fold >>> TRIG_DROP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= s_drop[TRIG_W-1:0];
      cos_out <= c_drop[TRIG_W-1:0];
    end
  end

endmodule

>>> hw/rtl/s2c_product.sv
// ----------------------------------------------------------------------------
// s2c_product
// Three stages of magnitude products: depth times the first factor, then
// the second factor as two 32-bit partial products, then combine, truncate
// and saturate with the sign restored.
// ----------------------------------------------------------------------------
module s2c_product
  import s2c_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic signed [TRIG_W-1:0]  sin_t,
  input  logic signed [TRIG_W-1:0]  cos_t,
  input  logic signed [TRIG_W-1:0]  sin_p,
  input  logic signed [TRIG_W-1:0]  cos_p,
  output logic signed [COORD_W-1:0] x_mm,
  output logic signed [COORD_W-1:0] y_mm,
  output logic signed [COORD_W-1:0] z_mm
);

  function automatic logic [TRIG_W-1:0] mag(input logic signed [TRIG_W-1:0] v);
    return v[TRIG_W-1] ? TRIG_W'(-v) : TRIG_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic [63:0] m, input logic neg);
    logic [COORD_W-1:0] r;
    if (neg) begin
      r = (m >= 64'(COORD_MIN)) ? COORD_MIN : COORD_W'(-m);
    end else begin
      r = (m > 64'(COORD_MAX)) ? COORD_MAX : m[COORD_W-1:0];
    end
    return r;
  endfunction

  // stage one
  logic [63:0]       a_st;
  logic [63:0]       a_ct;
  logic [TRIG_W-1:0] m_cp;
  logic [TRIG_W-1:0] m_sp;
  logic              neg_x1, neg_y1, neg_z1;

  // stage two
  logic [63:0] ph_x, pl_x, ph_y, pl_y;
  logic [63:0] zmag;
  logic        neg_x2, neg_y2, neg_z2;

  logic [63:0] hi_x, hi_y;

  always_ff @(posedge clk) begin
    if (en) begin
      a_st   <= 64'(depth) * 64'(mag(sin_t));
      a_ct   <= 64'(depth) * 64'(mag(cos_t));
      m_cp   <= mag(cos_p);
      m_sp   <= mag(sin_p);
      neg_x1 <= sin_t[TRIG_W-1] ^ cos_p[TRIG_W-1];
      neg_y1 <= sin_t[TRIG_W-1] ^ sin_p[TRIG_W-1];
      neg_z1 <= cos_t[TRIG_W-1];

      ph_x   <= 64'(a_st[63:32]) * 64'(m_cp);
      pl_x   <= 64'(a_st[31:0]) * 64'(m_cp);
      ph_y   <= 64'(a_st[63:32]) * 64'(m_sp);
      pl_y   <= 64'(a_st[31:0]) * 64'(m_sp);
      zmag   <= a_ct >> TRIG_FRACTION_BITS;
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      neg_z2 <= neg_z1;

      x_mm   <= signed'(sat(hi_x >> MAG_SHIFT, neg_x2));
      y_mm   <= signed'(sat(hi_y >> MAG_SHIFT, neg_y2));
      z_mm   <= signed'(sat(zmag, neg_z2));
    end
  end

  assign hi_x = ph_x + (pl_x >> 32);
  assign hi_y = ph_y + (pl_y >> 32);

endmodule

>>> hw/rtl/spherical_to_cartesian_point.sv
// Each accepted point passes the angle prep stages, the CORDIC steps, the fold stage and the product stages in order.
// Throughput: one point per cycle while the output is not stalled; each CORDIC iteration is its own register stage.
// The whole pipeline advances together and holds while the output word is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// spherical_to_cartesian_point
// Pipelined lidar point converter from depth and two angles to x, y and z.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_point
  import s2c_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int LAST = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] vld;
  side_t                 sb [PIPE_DEPTH];
  logic                  en;

  logic signed [CORDIC_W-1:0] z_t, z_p;
  quad_t                      q_t, q_p;
  logic signed [TRIG_W-1:0]   sin_t, cos_t, sin_p, cos_p;
  logic signed [COORD_W-1:0]  x_r, y_r, z_r;

  // advance every stage when the output word is free or being taken
  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{depth_mm: in_data.depth_mm, reflect: in_data.reflect_in,
                 tag: in_data.tag_in, last: in_data.last_in};
    end
  end

  for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  s2c_angle_prep u_prep_t (
    .clk(clk), .en(en), .angle(in_data.polar_centideg),
    .z_out(z_t), .quad_out(q_t)
  );

  s2c_angle_prep u_prep_p (
    .clk(clk), .en(en), .angle(in_data.azimuth_centideg),
    .z_out(z_p), .quad_out(q_p)
  );

  s2c_cordic u_cordic_t (
    .clk(clk), .en(en), .z_in(z_t), .quad_in(q_t),
    .sin_out(sin_t), .cos_out(cos_t)
  );

  s2c_cordic u_cordic_p (
    .clk(clk), .en(en), .z_in(z_p), .quad_in(q_p),
    .sin_out(sin_p), .cos_out(cos_p)
  );

  s2c_product u_product (
    .clk(clk), .en(en), .depth(sb[DEPTH_TAP].depth_mm),
    .sin_t(sin_t), .cos_t(cos_t), .sin_p(sin_p), .cos_p(cos_p),
    .x_mm(x_r), .y_mm(y_r), .z_mm(z_r)
  );

  assign out_data = '{x_mm: x_r, y_mm: y_r, z_mm: z_r,
                      reflect_out: sb[LAST].reflect, tag_out: sb[LAST].tag,
                      last_out: sb[LAST].last};

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_last_arrives: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAST-1] |=> out_valid)
    else $error("word lost before the output stage");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    en && !vld[LAST-1] |=> !out_valid)
    else $error("output word appeared without a source");

  a_take_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word not captured in the first stage");

endmodule

>>> verif/spherical_to_cartesian_point_tb.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_point_tb
// Drives lidar points through the converter with random gaps and stalls on both
// sides. Each accepted word is predicted in fixed point, using CORDIC sine and
// cosine, and checked field by field against the words that come out.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_point_tb;
  import s2c_pkg::*;

  localparam int  N_RANDOM    = 1130;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  LONG_HOLD   = 300;
  localparam longint GAIN     = 652032874;
  localparam longint RAD_Q46  = 64'd12281662764;

  // Fixed-point point converter and the queue of points still owed.
  class point_scoreboard;
    out_word_t owed[$];
    int        errors;
    int        checked;

    function automatic void trig(input logic [15:0] angle, output longint sn,
                                 output longint cs);
      longint unsigned a, r;
      longint          x, y, z, dx, dy, s, c;
      quad_t           q;
      a = angle % 36000;
      q = quad_t'(a / 9000);
      r = a - 9000 * longint'(q);
      x = GAIN;
      y = 0;
      z = longint'((r * RAD_Q46 + 32768) >> 16);
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_q30(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_q30(i));
        end
      end
      case (q)
        QUAD_0: begin s = y;  c = x;  end
        QUAD_1: begin s = x;  c = -y; end
        QUAD_2: begin s = -y; c = -x; end
        default: begin s = -x; c = y; end
      endcase
      sn = s >>> (30 - TRIG_FRACTION_BITS);
      cs = c >>> (30 - TRIG_FRACTION_BITS);
    endfunction

    function automatic logic [31:0] clamp(input logic [127:0] mag, input bit neg);
      if (neg) begin
        if (mag >= 128'h8000_0000) return COORD_MIN;
        return 32'(-mag);
      end
      if (mag > 128'h7FFF_FFFF) return COORD_MAX;
      return mag[31:0];
    endfunction

    function automatic longint unsigned absval(input longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic logic [31:0] scale2(input logic [31:0] depth, input longint f1,
                                           input longint f2);
      logic [127:0] p;
      p = 128'(depth) * 128'(absval(f1)) * 128'(absval(f2));
      return clamp(p >> (2 * TRIG_FRACTION_BITS), (f1 < 0) != (f2 < 0));
    endfunction

    function void note(in_word_t w);
      longint    st, ct, sp, cp;
      out_word_t e;
      trig(w.polar_centideg, st, ct);
      trig(w.azimuth_centideg, sp, cp);
      e.x_mm        = scale2(w.depth_mm, st, cp);
      e.y_mm        = scale2(w.depth_mm, st, sp);
      e.z_mm        = clamp((128'(w.depth_mm) * 128'(absval(ct))) >> TRIG_FRACTION_BITS,
                            ct < 0);
      e.reflect_out = w.reflect_in;
      e.tag_out     = w.tag_in;
      e.last_out    = w.last_in;
      owed = {owed, e};
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check(out_word_t got);
      out_word_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none actual %h", $time, got);
        return;
      end
      e = owed.pop_front();
      checked++;
      field("x_mm", e.x_mm, got.x_mm);
      field("y_mm", e.y_mm, got.y_mm);
      field("z_mm", e.z_mm, got.z_mm);
      field("reflect_out", e.reflect_out, got.reflect_out);
      field("tag_out", e.tag_out, got.tag_out);
      field("last_out", e.last_out, got.last_out);
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;

  point_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  hold_done = 0;

  spherical_to_cartesian_point u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("spherical_to_cartesian_point: mismatch");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note(w);
    sent++;
    @(negedge clk);
  endtask

  function automatic in_word_t mk(logic [31:0] d, logic [15:0] p, logic [15:0] a,
                                  logic [7:0] r, logic [7:0] t, logic l);
    in_word_t w;
    w.depth_mm = d; w.polar_centideg = p; w.azimuth_centideg = a;
    w.reflect_in = r; w.tag_in = t; w.last_in = l;
    return w;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 3) * 9000 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 35999));
    endcase
  endfunction

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom_range(0, 300000);
    endcase
  endfunction

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sb.checked >= 300) begin
        hold_done = 1;
        out_ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = ((sb.checked / 80) % 3 == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      sb.check(out_data);
      @(negedge clk);
    end
  end

  initial begin
    in_word_t w;
    int       gap;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: quadrant edges, wrap-around, depth extremes, pass-through extremes
    send_word(mk(0, 0, 0, 8'h00, 8'h00, 0), 0);
    send_word(mk(0, 65535, 65535, 8'hFF, 8'hFF, 1), 0);
    send_word(mk(32'hFFFF_FFFF, 0, 0, 8'hAA, 8'h55, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 9000, 0, 8'h55, 8'hAA, 1), 0);
    send_word(mk(32'hFFFF_FFFF, 9000, 9000, 1, 2, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 9000, 18000, 3, 4, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 9000, 27000, 5, 6, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 18000, 4500, 7, 8, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 27000, 13500, 9, 10, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 35999, 35999, 11, 12, 1), 0);
    send_word(mk(1000, 36000, 36000, 13, 14, 0), 0);
    send_word(mk(1000, 45000, 63000, 15, 16, 0), 0);
    send_word(mk(1000, 65535, 0, 17, 18, 0), 0);
    send_word(mk(32'h8000_0000, 4500, 4500, 19, 20, 0), 0);
    send_word(mk(32'h7FFF_FFFF, 13500, 22500, 21, 22, 1), 0);
    send_word(mk(1, 8999, 9001, 23, 24, 0), 0);
    send_word(mk(12345, 17999, 26999, 25, 26, 0), 0);
    send_word(mk(32'hFFFF_FFFF, 18000, 18000, 27, 28, 1), 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 600) begin
        in_valid = 0;
        while (sb.owed.size() != 0) @(negedge clk);
      end
      w = mk(pick_depth(), pick_angle(), pick_angle(), 8'($urandom()),
             8'($urandom()), 1'($urandom()));
      // back-to-back bursts around the long hold so the pipeline fills
      if ((i / 100) % 3 == 0 || (i >= 280 && i < 420)) gap = 0;
      else gap = $urandom_range(0, 15);
      send_word(w, gap);
    end
    in_valid = 0;

    while (sb.owed.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 20) @(negedge clk);

    $display("sent %0d points, checked %0d results over quadrants, wrap and saturation",
             sent, sb.checked);
    $display("ran with random gaps, stalls and one long output hold-off");
    if (sb.errors == 0) begin
      $display("spherical_to_cartesian_point: match");
    end else begin
      $display("spherical_to_cartesian_point: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/s2c_pkg.sv
hw/rtl/s2c_angle_prep.sv
hw/rtl/s2c_cordic.sv
hw/rtl/s2c_product.sv
hw/rtl/spherical_to_cartesian_point.sv
verif/spherical_to_cartesian_point_tb.sv
